### rtl/ust_pkg.sv
// ----------------------------------------------------------------------------
// ust_pkg: shared types and constants of the Unicode stream transcoder
// Beat formats, format and error codes, register select codes and the
// job record handed from the classifier to the emitter.
// ----------------------------------------------------------------------------
package ust_pkg;

  localparam logic [1:0] FMT_UTF8  = 2'd0;
  localparam logic [1:0] FMT_UTF16 = 2'd1;
  localparam logic [1:0] FMT_UTF32 = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_RANGE     = 2'd3;

  localparam logic REG_SOURCE_FORMAT = 1'b0;
  localparam logic REG_TARGET_FORMAT = 1'b1;

  localparam logic [1:0] SOURCE_FORMAT_RST = FMT_UTF8;
  localparam logic [1:0] TARGET_FORMAT_RST = FMT_UTF16;

  localparam int CP_W    = 21;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [CP_W-1:0] CP_MAX_UNICODE = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_PLANE1      = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX_1BYTE   = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MAX_2BYTE   = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_MAX_BMP     = 21'h00FFFF;

  typedef struct packed {
    logic [31:0] in_unit;
    logic        in_text_end;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0] out_unit;
    logic            run_last;
    logic            text_done;
    logic [1:0]      error_code;
  } out_beat_t;

  typedef struct packed {
    logic [3:0][CP_W-1:0] units;
    logic [1:0]           last_idx;
    logic                 text_done;
    logic [1:0]           error_code;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/ust_front.sv
// ----------------------------------------------------------------------------
// ust_front: unit classifier
// Accepts source beats, decodes code points with the held UTF-8 and surrogate
// state, re-encodes to target units and queues a job per code point or error.
// ----------------------------------------------------------------------------
module ust_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ust_pkg::in_beat_t in_beat,
  input  logic [1:0]        src_fmt,
  input  logic [1:0]        tgt_fmt,
  input  logic              dec_clear,
  input  ust_pkg::q_status_t q_status,
  output logic              q_push,
  output ust_pkg::job_t     q_job
);
  import ust_pkg::*;

  logic [CP_W-1:0] part_r, part_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic            hs_r, hs_nxt;
  logic            halt_r, halt_nxt;

  logic [31:0]          u;
  logic                 text_end;
  logic                 fire;
  logic [CP_W-1:0]      cp;
  logic                 cp_ok;
  logic [1:0]           dec_err;
  logic [1:0]           err;
  logic [CP_W-1:0]      cont_cp;
  logic [CP_W-1:0]      pair_cp;
  logic                 u16_low;
  logic                 u16_high;
  logic [3:0][CP_W-1:0] enc_units;
  logic [1:0]           enc_last;
  logic [1:0]           enc_err;
  logic [CP_W-1:0]      cp_off;

  function automatic logic [CP_W-1:0] cont_byte(input logic [5:0] bits);
    cont_byte = {13'd0, 2'b10, bits};
  endfunction

  assign u        = in_beat.in_unit;
  assign text_end = in_beat.in_text_end;
  assign in_stall = q_status.full;
  assign fire     = in_valid && !in_stall;
  assign cont_cp  = {part_r[14:0], u[5:0]};
  assign pair_cp  = CP_PLANE1 + {1'b0, part_r[9:0], u[9:0]};
  assign u16_low  = (u[15:10] == 6'b110111);
  assign u16_high = (u[15:10] == 6'b110110);
  assign cp_off   = cp - CP_PLANE1;

  always_comb begin
    part_nxt = part_r;
    pend_nxt = pend_r;
    hs_nxt   = hs_r;
    cp       = '0;
    cp_ok    = 1'b0;
    dec_err  = ERR_NONE;
    unique case (src_fmt)
      FMT_UTF8: begin
        if (|u[31:8]) begin
          dec_err = ERR_MALFORMED;
        end else if (pend_r != 2'd0) begin
          if (u[7:6] != 2'b10) begin
            dec_err = ERR_MALFORMED;
          end else begin
            pend_nxt = pend_r - 2'd1;
            if (pend_r == 2'd1) begin
              cp       = cont_cp;
              cp_ok    = 1'b1;
              part_nxt = '0;
            end else begin
              part_nxt = cont_cp;
            end
          end
        end else if (u[7] == 1'b0) begin
          cp    = {14'd0, u[6:0]};
          cp_ok = 1'b1;
        end else if (u[7:5] == 3'b110) begin
          part_nxt = {16'd0, u[4:0]};
          pend_nxt = 2'd1;
        end else if (u[7:4] == 4'b1110) begin
          part_nxt = {17'd0, u[3:0]};
          pend_nxt = 2'd2;
        end else if (u[7:3] == 5'b11110) begin
          part_nxt = {18'd0, u[2:0]};
          pend_nxt = 2'd3;
        end else begin
          dec_err = ERR_MALFORMED;
        end
      end
      FMT_UTF16: begin
        if (|u[31:16]) begin
          dec_err = ERR_MALFORMED;
        end else if (hs_r) begin
          if (!u16_low) begin
            dec_err = ERR_MALFORMED;
          end else begin
            cp       = pair_cp;
            cp_ok    = 1'b1;
            hs_nxt   = 1'b0;
            part_nxt = '0;
          end
        end else if (u16_high) begin
          part_nxt = {11'd0, u[9:0]};
          hs_nxt   = 1'b1;
        end else if (u16_low) begin
          dec_err = ERR_MALFORMED;
        end else begin
          cp    = {5'd0, u[15:0]};
          cp_ok = 1'b1;
        end
      end
      default: begin
        if (|u[31:21]) begin
          dec_err = ERR_RANGE;
        end else begin
          cp    = u[20:0];
          cp_ok = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    enc_units = '0;
    enc_last  = 2'd0;
    enc_err   = ERR_NONE;
    enc_units[0] = cp;
    if (tgt_fmt == FMT_UTF8 || tgt_fmt == FMT_UTF16) begin
      if (cp > CP_MAX_UNICODE) begin
        enc_err = ERR_RANGE;
      end else if (tgt_fmt == FMT_UTF16) begin
        if (cp > CP_MAX_BMP) begin
          enc_units[0] = {5'd0, 6'b110110, cp_off[19:10]};
          enc_units[1] = {5'd0, 6'b110111, cp_off[9:0]};
          enc_last     = 2'd1;
        end
      end else if (cp > CP_MAX_BMP) begin
        enc_units[0] = {13'd0, 5'b11110, cp[20:18]};
        enc_units[1] = cont_byte(cp[17:12]);
        enc_units[2] = cont_byte(cp[11:6]);
        enc_units[3] = cont_byte(cp[5:0]);
        enc_last     = 2'd3;
      end else if (cp > CP_MAX_2BYTE) begin
        enc_units[0] = {13'd0, 4'b1110, cp[15:12]};
        enc_units[1] = cont_byte(cp[11:6]);
        enc_units[2] = cont_byte(cp[5:0]);
        enc_last     = 2'd2;
      end else if (cp > CP_MAX_1BYTE) begin
        enc_units[0] = {13'd0, 3'b110, cp[10:6]};
        enc_units[1] = cont_byte(cp[5:0]);
        enc_last     = 2'd1;
      end
    end
  end

  always_comb begin
    err = dec_err;
    if (dec_err == ERR_NONE && cp_ok) begin
      err = enc_err;
    end
    if (err == ERR_NONE && text_end && (pend_nxt != 2'd0 || hs_nxt)) begin
      err = ERR_TRUNCATED;
    end
  end

  always_comb begin
    q_push   = 1'b0;
    q_job    = '0;
    halt_nxt = halt_r;
    if (fire) begin
      if (halt_r) begin
        if (text_end) begin
          halt_nxt = 1'b0;
        end
      end else if (err != ERR_NONE) begin
        q_push           = 1'b1;
        q_job.text_done  = 1'b1;
        q_job.error_code = err;
        halt_nxt         = !text_end;
      end else if (cp_ok) begin
        q_push          = 1'b1;
        q_job.units     = enc_units;
        q_job.last_idx  = enc_last;
        q_job.text_done = text_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pend_r <= '0;
      hs_r   <= 1'b0;
      halt_r <= 1'b0;
    end else begin
      halt_r <= halt_nxt;
      if (dec_clear || (fire && (halt_r || text_end || err != ERR_NONE))) begin
        part_r <= '0;
        pend_r <= '0;
        hs_r   <= 1'b0;
      end else if (fire) begin
        part_r <= part_nxt;
        pend_r <= pend_nxt;
        hs_r   <= hs_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (pend_r == 2'd0 && !hs_r))
    else $error("decoder state held while halted");
  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r != 2'd0 && hs_r))
    else $error("UTF-8 and surrogate pending at once");
`endif

endmodule

### rtl/ust_fifo.sv
// ----------------------------------------------------------------------------
// ust_fifo: job queue
// Short register queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module ust_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ust_pkg::job_t      push_job,
  input  logic               pop,
  output ust_pkg::job_t      head_job,
  output ust_pkg::q_status_t status
);
  import ust_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r;
  logic [Q_AW-1:0] rptr_r;
  logic [Q_AW:0]   cnt_r;

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head_job     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!status.full || pop))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("job queue underflow");
`endif

endmodule

### rtl/ust_back.sv
// ----------------------------------------------------------------------------
// ust_back: unit emitter
// Walks the head job one target unit per beat into the output register and
// retires the job with its last unit.
// ----------------------------------------------------------------------------
module ust_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ust_pkg::job_t      head_job,
  input  ust_pkg::q_status_t q_status,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ust_pkg::out_beat_t out_beat
);
  import ust_pkg::*;

  logic      out_valid_r;
  out_beat_t out_beat_r;
  logic [1:0] idx_r;
  logic      out_ready;
  logic      take;
  logic      at_last;

  assign out_ready = !out_valid_r || !out_stall;
  assign take      = !q_status.empty && out_ready;
  assign at_last   = (idx_r == head_job.last_idx);
  assign q_pop     = take && at_last;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (out_ready) begin
      out_valid_r <= !q_status.empty;
      if (take) begin
        idx_r <= at_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_beat_r.out_unit   <= head_job.units[idx_r];
      out_beat_r.run_last   <= at_last;
      out_beat_r.text_done  <= at_last && head_job.text_done;
      out_beat_r.error_code <= head_job.error_code;
    end
  end

`ifndef ASSERT_OFF
  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.error_code != ERR_NONE) |->
      (out_beat_r.out_unit == '0 && out_beat_r.run_last && out_beat_r.text_done))
    else $error("error beat not a lone zero unit");
`endif

endmodule

### rtl/unicode_stream_transcoder.sv
// ----------------------------------------------------------------------------
// unicode_stream_transcoder: streaming UTF-8 / UTF-16 / UTF-32 re-encoder
// Takes one source code unit per input beat and gives zero to four target
// code units, one per output beat. The classifier takes a new input beat every
// cycle while its two-entry job queue has room; the emitter drains one target
// unit per cycle while the output is not stalled. Results pass through the
// job queue and then the output register. The result rate is set by the
// single output register. Registers: source_format at byte 0x0, target_format
// at 0x4; writing source_format drops any partial sequence or held surrogate.
// ----------------------------------------------------------------------------
module unicode_stream_transcoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ust_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output ust_pkg::out_beat_t out_beat,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ust_pkg::*;

  logic [1:0] src_fmt_r;
  logic [1:0] tgt_fmt_r;
  logic       cfg_wr;
  logic       dec_clear;
  logic       q_push;
  logic       q_pop;
  job_t       q_job;
  job_t       head_job;
  q_status_t  q_status;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign dec_clear = cfg_wr && (paddr[2] == REG_SOURCE_FORMAT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= SOURCE_FORMAT_RST;
      tgt_fmt_r <= TARGET_FORMAT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SOURCE_FORMAT: src_fmt_r <= pwdata[1:0];
        REG_TARGET_FORMAT: tgt_fmt_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_FORMAT: prdata = {30'd0, src_fmt_r};
      REG_TARGET_FORMAT: prdata = {30'd0, tgt_fmt_r};
      default:           prdata = '0;
    endcase
  end

  ust_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .src_fmt   (src_fmt_r),
    .tgt_fmt   (tgt_fmt_r),
    .dec_clear (dec_clear),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  ust_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  ust_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

### tb/unicode_stream_transcoder_checker.sv
// ----------------------------------------------------------------------------
// unicode_stream_transcoder_checker: result predictor and comparator
// Watches the input, result and register ports of the transcoder. It keeps
// its own copy of the format registers and decoder state, works out the
// target units that every accepted input beat should give, and compares each
// accepted result beat field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unicode_stream_transcoder_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ust_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ust_pkg::out_beat_t out_beat,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  import ust_pkg::*;

  logic [1:0]      src_fmt;
  logic [1:0]      tgt_fmt;
  logic [CP_W-1:0] partial_cp;
  logic [1:0]      bytes_left;
  logic            hi_held;
  logic            halted;
  out_beat_t       expected_units[$];
  int              fails = 0;

  task automatic clear_decoder();
    partial_cp = '0;
    bytes_left = '0;
    hi_held    = 1'b0;
  endtask

  task automatic transcode_unit(input in_beat_t b);
    logic [31:0]     u;
    logic            fin;
    logic            have_cp;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] v;
    logic [CP_W-1:0] units [4];
    logic [1:0]      err;
    out_beat_t       ob;
    int              n;
    int              k;
    u       = b.in_unit;
    fin     = b.in_text_end;
    have_cp = 1'b0;
    cp      = '0;
    err     = ERR_NONE;
    n       = 0;
    if (halted) begin
      if (fin) begin
        halted = 1'b0;
        clear_decoder();
      end
      return;
    end
    case (src_fmt)
      FMT_UTF8: begin
        if (u > 32'hFF) begin
          err = ERR_MALFORMED;
        end else if (bytes_left != 2'd0) begin
          if (u[7:6] != 2'b10) begin
            err = ERR_MALFORMED;
          end else begin
            partial_cp = {partial_cp[14:0], u[5:0]};
            bytes_left = bytes_left - 2'd1;
            if (bytes_left == 2'd0) begin
              cp         = partial_cp;
              partial_cp = '0;
              have_cp    = 1'b1;
            end
          end
        end else if (!u[7]) begin
          cp      = u[CP_W-1:0];
          have_cp = 1'b1;
        end else if (u[7:5] == 3'b110) begin
          partial_cp = {16'd0, u[4:0]};
          bytes_left = 2'd1;
        end else if (u[7:4] == 4'b1110) begin
          partial_cp = {17'd0, u[3:0]};
          bytes_left = 2'd2;
        end else if (u[7:3] == 5'b11110) begin
          partial_cp = {18'd0, u[2:0]};
          bytes_left = 2'd3;
        end else begin
          err = ERR_MALFORMED;
        end
      end
      FMT_UTF16: begin
        if (u > 32'hFFFF) begin
          err = ERR_MALFORMED;
        end else if (hi_held) begin
          if (u[15:10] == 6'b110111) begin
            cp         = CP_PLANE1 + {1'b0, partial_cp[9:0], u[9:0]};
            hi_held    = 1'b0;
            partial_cp = '0;
            have_cp    = 1'b1;
          end else begin
            err = ERR_MALFORMED;
          end
        end else if (u[15:10] == 6'b110110) begin
          partial_cp = {11'd0, u[9:0]};
          hi_held    = 1'b1;
        end else if (u[15:10] == 6'b110111) begin
          err = ERR_MALFORMED;
        end else begin
          cp      = u[CP_W-1:0];
          have_cp = 1'b1;
        end
      end
      default: begin
        if (u > 32'h1FFFFF) begin
          err = ERR_RANGE;
        end else begin
          cp      = u[CP_W-1:0];
          have_cp = 1'b1;
        end
      end
    endcase

    if (have_cp && (tgt_fmt == FMT_UTF8 || tgt_fmt == FMT_UTF16) && cp > CP_MAX_UNICODE) begin
      err = ERR_RANGE;
    end else if (have_cp) begin
      case (tgt_fmt)
        FMT_UTF8: begin
          if (cp <= CP_MAX_1BYTE) begin
            units[0] = cp;
            n = 1;
          end else if (cp <= CP_MAX_2BYTE) begin
            units[0] = 21'hC0 | (cp >> 6);
            units[1] = 21'h80 | (cp & 21'h3F);
            n = 2;
          end else if (cp <= CP_MAX_BMP) begin
            units[0] = 21'hE0 | (cp >> 12);
            units[1] = 21'h80 | ((cp >> 6) & 21'h3F);
            units[2] = 21'h80 | (cp & 21'h3F);
            n = 3;
          end else begin
            units[0] = 21'hF0 | ((cp >> 18) & 21'h7);
            units[1] = 21'h80 | ((cp >> 12) & 21'h3F);
            units[2] = 21'h80 | ((cp >> 6) & 21'h3F);
            units[3] = 21'h80 | (cp & 21'h3F);
            n = 4;
          end
        end
        FMT_UTF16: begin
          if (cp < CP_PLANE1) begin
            units[0] = cp;
            n = 1;
          end else begin
            v = cp - CP_PLANE1;
            units[0] = 21'hD800 + (v >> 10);
            units[1] = 21'hDC00 + (v & 21'h3FF);
            n = 2;
          end
        end
        default: begin
          units[0] = cp;
          n = 1;
        end
      endcase
    end

    if (err == ERR_NONE && fin && (bytes_left != 2'd0 || hi_held)) err = ERR_TRUNCATED;

    if (err != ERR_NONE) begin
      ob.out_unit   = '0;
      ob.run_last   = 1'b1;
      ob.text_done  = 1'b1;
      ob.error_code = err;
      expected_units.push_back(ob);
      clear_decoder();
      halted = !fin;
      return;
    end
    if (fin) clear_decoder();
    for (k = 0; k < n; k++) begin
      ob.out_unit   = units[k];
      ob.run_last   = (k == n - 1);
      ob.text_done  = fin && (k == n - 1);
      ob.error_code = ERR_NONE;
      expected_units.push_back(ob);
    end
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    logic      bad;
    if (expected_units.size() == 0) begin
      $display("%0t: result beat expected none got %h", $time, got);
      fails++;
      return;
    end
    want = expected_units.pop_front();
    bad  = 1'b0;
    if (got.out_unit !== want.out_unit) begin
      $display("%0t: out_unit expected %h got %h", $time, want.out_unit, got.out_unit);
      bad = 1'b1;
    end
    if (got.run_last !== want.run_last) begin
      $display("%0t: run_last expected %b got %b", $time, want.run_last, got.run_last);
      bad = 1'b1;
    end
    if (got.text_done !== want.text_done) begin
      $display("%0t: text_done expected %b got %b", $time, want.text_done, got.text_done);
      bad = 1'b1;
    end
    if (got.error_code !== want.error_code) begin
      $display("%0t: error_code expected %0d got %0d", $time, want.error_code,
               got.error_code);
      bad = 1'b1;
    end
    if (bad) fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      src_fmt = SOURCE_FORMAT_RST;
      tgt_fmt = TARGET_FORMAT_RST;
      clear_decoder();
      halted = 1'b0;
      expected_units.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SOURCE_FORMAT) begin
          src_fmt = pwdata[1:0];
          clear_decoder();
        end else begin
          tgt_fmt = pwdata[1:0];
        end
      end
      // results come from earlier beats, so compare before predicting
      if (out_valid && !out_stall) check_beat(out_beat);
      if (in_valid && !in_stall) transcode_unit(in_beat);
    end
    pending    <= expected_units.size();
    fail_count <= fails;
  end

endmodule

### tb/unicode_stream_transcoder_tb.sv
// ----------------------------------------------------------------------------
// unicode_stream_transcoder_tb: top of the transcoder testbench
// Drives directed texts through the special cases of each encoding, then
// random well-formed texts with some corruption for every pair of source and
// target formats, with random gaps and stalls on both channels. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unicode_stream_transcoder_tb;

  import ust_pkg::*;

  localparam logic [1:0] FMT_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SETTLE      = 10;
  localparam int         RAND_ITEMS  = 260;
  localparam int         PHASES      = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_beat;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          item_count  = 0;
  bit          in_idle     = 1'b1;
  bit          out_idle    = 1'b1;

  unicode_stream_transcoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  unicode_stream_transcoder_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("unicode_stream_transcoder_tb: FAIL");
    $finish;
  end

  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      w = out_idle ? $urandom_range(0, 16) : 0;
      @(negedge clk);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [1:0] fmt_of(input int k);
    case (k)
      0:       return FMT_UTF8;
      1:       return FMT_UTF16;
      default: return FMT_UTF32;
    endcase
  endfunction

  function automatic logic [20:0] pick_cp(input logic [1:0] src);
    logic [20:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2: r = 21'($urandom_range(0, 'h7F));
      3, 4:    r = 21'($urandom_range('h80, 'h7FF));
      5, 6:    r = 21'($urandom_range('h800, 'hFFFF));
      7, 8:    r = 21'($urandom_range('h10000, 'h10FFFF));
      default: r = 21'($urandom_range('h110000, 'h1FFFFF));
    endcase
    if (src == FMT_UTF16) begin
      if (r > 21'h10FFFF) r = r - 21'h100000;
      if (r >= 21'hD800 && r <= 21'hDFFF) r = r ^ 21'h2000;
    end
    return r;
  endfunction

  function automatic logic [31:0] noise_unit();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 'hFF);
      2:       return $urandom_range('hD800, 'hDFFF);
      default: return $urandom_range(0, 'hFFFF);
    endcase
  endfunction

  task automatic send_unit(input logic [31:0] u, input logic fin);
    int gap;
    gap = in_idle ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_beat.in_unit     <= u;
    in_beat.in_text_end <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input logic [1:0] src);
    logic [31:0] units[$];
    logic [31:0] c;
    logic [20:0] v;
    logic        open_end;
    int          nchar;
    int          len;
    int          i;
    nchar = $urandom_range(1, 6);
    repeat (nchar) begin
      c = {11'd0, pick_cp(src)};
      case (src)
        FMT_UTF8: begin
          if (c <= 32'h7F) begin
            units.push_back(c);
          end else if (c <= 32'h7FF) begin
            units.push_back(32'hC0 | (c >> 6));
            units.push_back(32'h80 | (c & 32'h3F));
          end else if (c <= 32'hFFFF) begin
            units.push_back(32'hE0 | (c >> 12));
            units.push_back(32'h80 | ((c >> 6) & 32'h3F));
            units.push_back(32'h80 | (c & 32'h3F));
          end else begin
            units.push_back(32'hF0 | ((c >> 18) & 32'h7));
            units.push_back(32'h80 | ((c >> 12) & 32'h3F));
            units.push_back(32'h80 | ((c >> 6) & 32'h3F));
            units.push_back(32'h80 | (c & 32'h3F));
          end
        end
        FMT_UTF16: begin
          if (c < 32'h10000) begin
            units.push_back(c);
          end else begin
            v = c[20:0] - 21'h10000;
            units.push_back(32'hD800 | {22'd0, v[19:10]});
            units.push_back(32'hDC00 | {22'd0, v[9:0]});
          end
        end
        default: units.push_back(c);
      endcase
    end
    // corrupt one unit, cut the text short, or leave it open now and then
    if ($urandom_range(0, 7) == 0) units[$urandom_range(0, units.size() - 1)] = noise_unit();
    len = units.size();
    if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
    open_end = ($urandom_range(0, 9) == 0);
    for (i = 0; i < len; i++) send_unit(units[i], (i == len - 1) && !open_end);
    item_count += len;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_format(input logic reg_sel, input logic [1:0] code);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {30'd0, code};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int         phase;
    int         phase_end;
    logic [1:0] src;
    logic [1:0] tgt;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // UTF-8 in, UTF-16 out: ASCII extremes, surrogate pair, range, bad lead,
    // truncation, oversized unit
    send_unit(32'h00, 1'b0);
    send_unit(32'h7F, 1'b0);
    send_unit(32'hF0, 1'b0);
    send_unit(32'h9F, 1'b0);
    send_unit(32'h98, 1'b0);
    send_unit(32'h80, 1'b1);
    send_unit(32'hF4, 1'b0);
    send_unit(32'h90, 1'b0);
    send_unit(32'h80, 1'b0);
    send_unit(32'h80, 1'b1);
    send_unit(32'h80, 1'b0);
    send_unit(32'h41, 1'b1);
    send_unit(32'hE2, 1'b0);
    send_unit(32'h82, 1'b1);
    send_unit(32'h100, 1'b1);
    drain_results();

    // UTF-16 in, UTF-8 out: pair, largest two- and three-byte results, lone halves, oversized unit
    write_format(REG_SOURCE_FORMAT, FMT_UTF16);
    write_format(REG_TARGET_FORMAT, FMT_UTF8);
    send_unit(32'hD83D, 1'b0);
    send_unit(32'hDE00, 1'b0);
    send_unit(32'h07FF, 1'b0);
    send_unit(32'hFFFF, 1'b1);
    send_unit(32'hDC00, 1'b1);
    send_unit(32'hD800, 1'b1);
    send_unit(32'h10000, 1'b1);
    drain_results();

    // UTF-32 in: Unicode limit, above it, then the spare target code
    write_format(REG_SOURCE_FORMAT, FMT_UTF32);
    send_unit(32'h10FFFF, 1'b0);
    send_unit(32'h110000, 1'b1);
    drain_results();
    write_format(REG_TARGET_FORMAT, FMT_SPARE);
    send_unit(32'h1FFFFF, 1'b0);
    send_unit(32'hFFFFFFFF, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      src = (phase < 9) ? fmt_of(phase / 3) : FMT_SPARE;
      tgt = (phase < 9) ? fmt_of(phase % 3) : FMT_SPARE;
      drain_results();
      write_format(REG_TARGET_FORMAT, tgt);
      write_format(REG_SOURCE_FORMAT, src);
      in_idle   = ($urandom_range(0, 3) != 0);
      out_idle  = ($urandom_range(0, 3) != 0);
      phase_end = item_count + RAND_ITEMS / PHASES;
      while (item_count < phase_end) send_text(src);
      // leave a sequence open so the next source write must drop it
      if ($urandom_range(0, 1) == 1) begin
        if (src == FMT_UTF8) send_unit(32'hE0 | $urandom_range(0, 'hF), 1'b0);
        else if (src == FMT_UTF16) send_unit(32'hD800 + $urandom_range(0, 'h3FF), 1'b0);
      end
    end
    drain_results();

    if (fail_count == 0 && pending == 0) begin
      $display("unicode_stream_transcoder_tb: PASS");
    end else begin
      $display("unicode_stream_transcoder_tb: FAIL");
    end
    $finish;
  end

endmodule
